// ===== hdl/sbge_pkg.sv =====
package sbge_pkg;

    localparam int ID_W   = 15;
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int DATA_W = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_AIR_ID     = 2'd0;
    localparam logic [1:0] CFG_REMOVED_ID = 2'd1;

    localparam logic [6:0] GROUP_MASK = 7'h7F;

    typedef logic [1:0] t_cfg_index;

    typedef struct packed {
        logic [ID_W-1:0] block_id;
        logic            segment_start;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } t_out_beat;

    // status of the record queue as seen by its two sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hdl/sbge_fifo.sv =====
module sbge_fifo
    import sbge_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? next_ptr(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? next_ptr(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== hdl/sbge_front.sv =====
module sbge_front
    import sbge_pkg::*;
#(
    parameter int GAP_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  t_in_beat                    i_in_beat,
    input  t_q_status                   i_q_status,
    output logic                        o_in_stall,
    input  logic                        i_cfg_valid,
    input  t_cfg_index                  i_cfg_index,
    input  logic [DATA_W-1:0]           i_cfg_data,
    output logic                        o_push,
    output logic [GAP_WIDTH+WORD_W-1:0] o_record
);

    logic [ID_W-1:0]      r_air_id;
    logic [ID_W-1:0]      r_removed_id;
    logic [GAP_WIDTH-1:0] r_gap, n_gap;
    logic                 r_was_air, n_was_air;

    logic                 accept;
    logic                 is_air;
    logic                 skip;
    logic [GAP_WIDTH-1:0] base_gap;
    logic                 base_air;
    logic                 flag;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;

    // a segment start clears the run before the id is classified
    assign base_gap = i_in_beat.segment_start ? '0 : r_gap;
    assign base_air = i_in_beat.segment_start ? 1'b0 : r_was_air;
    assign is_air   = (i_in_beat.block_id == r_air_id);
    assign skip     = is_air || (i_in_beat.block_id == r_removed_id);
    assign flag     = !base_air && (base_gap != '0);

    always_comb begin
        n_gap     = r_gap;
        n_was_air = r_was_air;
        if (accept) begin
            if (skip) begin
                n_gap     = base_gap + GAP_WIDTH'(1);
                n_was_air = is_air;
            end else begin
                n_gap     = '0;
                n_was_air = base_air;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap        <= '0;
            r_was_air    <= 1'b0;
            r_air_id     <= ID_W'(0);
            r_removed_id <= ID_W'(1);
        end else begin
            r_gap     <= n_gap;
            r_was_air <= n_was_air;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_AIR_ID:     r_air_id     <= i_cfg_data[ID_W-1:0];
                    CFG_REMOVED_ID: r_removed_id <= i_cfg_data[ID_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_push   = accept && !skip;
    assign o_record = {base_gap, flag, i_in_beat.block_id};

endmodule

// ===== hdl/sbge_back.sv =====
module sbge_back
    import sbge_pkg::*;
#(
    parameter int GAP_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_q_status                   i_q_status,
    input  logic [GAP_WIDTH+WORD_W-1:0] i_record,
    output logic                        o_pop,
    output logic                        o_out_valid,
    output t_out_beat                   o_out_beat,
    input  logic                        i_out_stall
);

    typedef enum logic [1:0] {
        PH_GAP,
        PH_LOW,
        PH_HIGH
    } t_phase;

    t_phase               r_phase, n_phase;
    logic                 r_busy, n_busy;
    logic [GAP_WIDTH-1:0] r_gap, n_gap;
    logic [WORD_W-1:0]    r_word, n_word;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    logic                 can_load;
    logic                 adv;
    logic                 more;
    logic                 done;
    logic                 pop;

    assign can_load = !r_out_valid || !i_out_stall;
    assign adv      = r_busy && can_load;
    assign more     = |r_gap[GAP_WIDTH-1:7];

    always_comb begin
        n_phase     = r_phase;
        n_busy      = r_busy;
        n_gap       = r_gap;
        n_word      = r_word;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        done        = 1'b0;

        if (can_load) begin
            n_out_valid = adv;
        end
        if (adv) begin
            unique case (r_phase)
                PH_GAP: begin
                    n_out.out_byte  = {more, r_gap[6:0] & GROUP_MASK};
                    n_out.last_byte = 1'b0;
                    n_gap           = r_gap >> 7;
                    if (!more) begin
                        n_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    n_out.out_byte  = r_word[BYTE_W-1:0];
                    n_out.last_byte = 1'b0;
                    n_phase         = PH_HIGH;
                end
                PH_HIGH: begin
                    n_out.out_byte  = r_word[WORD_W-1:BYTE_W];
                    n_out.last_byte = 1'b1;
                    done            = 1'b1;
                    n_busy          = 1'b0;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end

        pop = !i_q_status.empty && (!r_busy || done);
        if (pop) begin
            n_gap   = i_record[GAP_WIDTH+WORD_W-1:WORD_W];
            n_word  = i_record[WORD_W-1:0];
            n_phase = PH_GAP;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_GAP;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_gap  <= n_gap;
        r_word <= n_word;
        r_out  <= n_out;
    end

    assign o_pop       = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// ===== hdl/sparse_block_gap_encoder.sv =====
// path: a record is queued, loaded into the back's registers, then registered as bytes
// throughput: one id beat per cycle unless the queue is full; skipped ids emit nothing
// output: one byte per cycle if not stalled; 3 to ceil(GAP_WIDTH/7)+2 bytes per record;
// the byte serialiser sets the sustained rate when records follow each other closely
// reset: synchronous active-low clears gap count, kind, queue and output valid;
// air id resets to 0 and removed id to 1
module sparse_block_gap_encoder
    import sbge_pkg::*;
#(
    parameter int GAP_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // block id stream
    input  logic              i_in_valid,
    input  t_in_beat          i_in_beat,
    output logic              o_in_stall,
    // encoded byte stream
    output logic              o_out_valid,
    output t_out_beat         o_out_beat,
    input  logic              i_out_stall,
    // register writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_index        i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    // a record is the gap count and the 16-bit id word (flag in bit 15)
    localparam int REC_W   = GAP_WIDTH + WORD_W;
    // room for a short burst of solid blocks while bytes drain
    localparam int Q_DEPTH = 4;

    logic             push;
    logic             pop;
    logic [REC_W-1:0] rec_in;
    logic [REC_W-1:0] rec_out;
    t_q_status        q_status;

    // registers are plain flops, so a write is always taken
    assign o_cfg_ready = 1'b1;

    // front: classify each id, keep the run count and kind, build records
    sbge_front #(
        .GAP_WIDTH (GAP_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_record    (rec_in)
    );

    // record queue decouples id intake from byte output
    sbge_fifo #(
        .WIDTH (REC_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (rec_in),
        .i_pop    (pop),
        .o_data   (rec_out),
        .o_status (q_status)
    );

    // back: varint groups low first, then id low and high byte
    sbge_back #(
        .GAP_WIDTH (GAP_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_record    (rec_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== hdl/sbge_checker.sv =====
module sbge_checker
    import sbge_pkg::*;
#(
    parameter int GAP_WIDTH = 16
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_beat o_out_beat,
    input logic      i_out_stall
);

    localparam int MAX_BYTES = (GAP_WIDTH + 6) / 7 + 2;
    localparam int RUN_W     = $clog2(MAX_BYTES + 1);

    logic             out_acc;
    logic [RUN_W-1:0] r_run;

    assign out_acc = o_out_valid && !i_out_stall;

    // beats since the last record end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (out_acc) begin
            if (o_out_beat.last_byte) begin
                r_run <= '0;
            end else if (r_run != RUN_W'(MAX_BYTES)) begin
                r_run <= r_run + RUN_W'(1);
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_min_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out_beat.last_byte |-> r_run >= RUN_W'(2))
        else $error("record shorter than three bytes");

    a_max_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_run < RUN_W'(MAX_BYTES))
        else $error("record longer than the longest varint allows");

endmodule

bind sparse_block_gap_encoder sbge_checker #(
    .GAP_WIDTH (GAP_WIDTH)
) u_sbge_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_beat  (o_out_beat),
    .i_out_stall (i_out_stall)
);

// ===== tb/sparse_block_gap_encoder_tb.sv =====
module sparse_block_gap_encoder_tb;

    import sbge_pkg::*;

    localparam int GAP_W = 16;

    // index with no register behind it, writes to it must be ignored
    localparam t_cfg_index CFG_SPARE = 2'd3;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_beat   i_in_beat   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_beat  o_out_beat;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index = CFG_AIR_ID;
    logic [DATA_W-1:0] i_cfg_data = '0;

    sparse_block_gap_encoder #(
        .GAP_WIDTH(GAP_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_beat (o_out_beat),
        .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // block ids waiting for the driver, filled by the stimulus process
    t_in_beat  ids_to_send[$];
    // bytes the encoder owes us, oldest first
    t_out_beat expected_bytes[$];

    // predictor state, mirrors the encoder's gap tracking and registers
    logic [GAP_W-1:0] skip_run     = '0;
    logic             run_was_air  = 1'b0;
    logic [ID_W-1:0]  air_code     = '0;
    logic [ID_W-1:0]  removed_code = 15'd1;

    // stimulus side copy of the registers, used to aim ids at the skip codes
    logic [ID_W-1:0] cur_air     = '0;
    logic [ID_W-1:0] cur_removed = 15'd1;

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    logic rx_hold    = 1'b0;
    logic in_fire    = 1'b0;

    int mismatches   = 0;
    int n_in_beats   = 0;
    int n_out_bytes  = 0;
    int n_cfg_writes = 0;
    int n_in_stalls  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the encoder hangs
    initial begin
        #2000000;
        $display("sparse_block_gap_encoder_tb: done, errors");
        $finish;
    end

    // works out the record that one accepted id beat produces, if any
    task automatic encode_block(input t_in_beat b);
        logic [GAP_W-1:0]  rest;
        logic [WORD_W-1:0] word;
        t_out_beat         ob;
        if (b.segment_start) begin
            skip_run    = '0;
            run_was_air = 1'b0;
        end
        if (b.block_id == air_code || b.block_id == removed_code) begin
            // air wins when both codes match
            run_was_air = (b.block_id == air_code);
            skip_run    = skip_run + 1'b1;
        end else begin
            // gap as varint, seven bits per byte, low group first
            rest = skip_run;
            do begin
                ob.out_byte[6:0] = rest[6:0];
                rest             = rest >> 7;
                ob.out_byte[7]   = (rest != 0);
                ob.last_byte     = 1'b0;
                expected_bytes.push_back(ob);
            end while (rest != 0);
            // top bit flags a gap that ended on a removed block
            word = {!run_was_air && skip_run != 0, b.block_id};
            ob.out_byte  = word[7:0];
            ob.last_byte = 1'b0;
            expected_bytes.push_back(ob);
            ob.out_byte  = word[15:8];
            ob.last_byte = 1'b1;
            expected_bytes.push_back(ob);
            skip_run = '0;
        end
    endtask

    // monitor: register writes, accepted id beats and output bytes, all at the rising edge
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            skip_run     = '0;
            run_was_air  = 1'b0;
            air_code     = '0;
            removed_code = 15'd1;
            in_fire     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg_writes++;
                if (i_cfg_index == CFG_AIR_ID)
                    air_code = i_cfg_data[ID_W-1:0];
                else if (i_cfg_index == CFG_REMOVED_ID)
                    removed_code = i_cfg_data[ID_W-1:0];
            end
            if (i_in_valid && o_in_stall)
                n_in_stalls++;
            if (i_in_valid && !o_in_stall) begin
                encode_block(i_in_beat);
                n_in_beats++;
                in_fire <= 1'b1;
            end else begin
                in_fire <= 1'b0;
            end
            if (o_out_valid && !i_out_stall) begin
                n_out_bytes++;
                if (expected_bytes.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected byte %h last %b", o_out_beat.out_byte,
                                 o_out_beat.last_byte);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_beat.out_byte !== want.out_byte ||
                        o_out_beat.last_byte !== want.last_byte) begin
                        if (mismatches < 10)
                            $display("byte %0d: expected %h last %b, got %h last %b",
                                     n_out_bytes, want.out_byte, want.last_byte,
                                     o_out_beat.out_byte, o_out_beat.last_byte);
                        mismatches++;
                    end
                end
            end
        end
    end

    // driver: a new beat goes up only once the previous one has been taken,
    // so a stalled beat holds its payload
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (ids_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_in_beat  <= ids_to_send.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, random or a long hold-off
    always @(negedge i_clk) begin
        i_out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end

    task automatic hold_receiver(input int cycles);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold = 1'b0;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        @(posedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // called at a falling edge with the encoder idle
    task automatic cfg_write(input t_cfg_index idx, input logic [DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == CFG_AIR_ID)
            cur_air = data[ID_W-1:0];
        else if (idx == CFG_REMOVED_ID)
            cur_removed = data[ID_W-1:0];
    endtask

    task automatic send_id(input logic [ID_W-1:0] id, input logic start);
        t_in_beat b;
        b.block_id      = id;
        b.segment_start = start;
        ids_to_send.push_back(b);
    endtask

    task automatic send_gap(input logic [ID_W-1:0] id, input int len);
        for (int k = 0; k < len; k++)
            send_id(id, 1'b0);
    endtask

    // sender stops until every byte owed has come out, then lets a skipped
    // beat still in the pipe settle
    task automatic drain;
        do @(negedge i_clk);
        while (ids_to_send.size() != 0 || i_in_valid || expected_bytes.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // mostly single skipped or solid blocks, now and then a short run of
    // skipped ids, segment starts sprinkled in
    task automatic send_random(input int count);
        int pick;
        logic start;
        logic [ID_W-1:0] skip_code;
        for (int k = 0; k < count; k++) begin
            pick      = $urandom_range(99);
            start     = ($urandom_range(11) == 0);
            skip_code = $urandom_range(1) ? cur_air : cur_removed;
            if (pick < 8) begin
                send_id(skip_code, start);
                send_gap(skip_code, $urandom_range(3, 1));
            end else if (pick < 40) begin
                send_id(cur_air, start);
            end else if (pick < 55) begin
                send_id(cur_removed, start);
            end else begin
                send_id(ID_W'($urandom_range(32767)), start);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // phase 1: reset codes, directed records
        set_idling(6, 78);
        @(negedge i_clk);
        cfg_write(CFG_AIR_ID, 16'd0);
        cfg_write(CFG_REMOVED_ID, 16'd1);
        send_id(15'd5, 1'b0);             // no gap at all
        send_id(15'd0, 1'b0);             // one air then the widest id
        send_id(15'h7FFF, 1'b0);
        send_id(15'd1, 1'b0);             // one removed, flag bit expected
        send_id(15'd2, 1'b0);
        send_id(15'd0, 1'b0);             // air then removed, removed decides
        send_id(15'd1, 1'b0);
        send_id(15'd100, 1'b0);
        send_id(15'd1, 1'b0);             // removed then air, air decides
        send_id(15'd0, 1'b0);
        send_id(15'd100, 1'b0);
        send_id(15'd0, 1'b0);             // segment start on a solid block drops the gap
        send_id(15'd1, 1'b0);
        send_id(15'h4000, 1'b1);
        send_id(15'd1, 1'b0);             // segment start on an air block restarts the gap
        send_id(15'd0, 1'b1);
        send_id(15'h2AAA, 1'b0);
        send_id(15'd0, 1'b0);             // segment start on a removed block
        send_id(15'd1, 1'b1);
        send_id(15'h5555, 1'b0);
        // varint length boundary between one and two bytes
        send_gap(15'd1, 127);
        send_id(15'd7, 1'b0);
        send_gap(15'd0, 128);
        send_id(15'd8, 1'b0);
        drain;

        // phase 2: codes at the extremes, spare bits set in the write data;
        // the receiver holds off for a long stretch so the encoder backs up
        cfg_write(CFG_AIR_ID, 16'hFFFF);
        cfg_write(CFG_REMOVED_ID, 16'h8000);
        cfg_write(CFG_SPARE, 16'h1234);
        fork
            hold_receiver(400);
        join_none
        send_random(35);
        drain;

        // phase 3: idling the other way round, air and removed the same code
        set_idling(78, 6);
        @(negedge i_clk);
        cfg_write(CFG_AIR_ID, 16'h8000 | 16'd21845);
        cfg_write(CFG_REMOVED_ID, 16'd21845);
        send_random(15);
        drain;
        cfg_write(CFG_AIR_ID, 16'($urandom));
        cfg_write(CFG_REMOVED_ID, 16'($urandom));
        send_random(10);
        drain;
        send_random(10);
        drain;

        // phase 4: no idling on either side
        set_idling(0, 0);
        @(negedge i_clk);
        cfg_write(CFG_AIR_ID, 16'($urandom));
        cfg_write(CFG_REMOVED_ID, 16'($urandom));
        send_random(20);
        // trailing gap, nothing may come out for it
        send_id(cur_air, 1'b0);
        send_id(cur_removed, 1'b0);
        drain;

        if (expected_bytes.size() != 0)
            mismatches++;
        $display("run covered %0d id beats (%0d stalled cycles) and %0d output bytes",
                 n_in_beats, n_in_stalls, n_out_bytes);
        $display("over %0d register writes, %0d mismatches", n_cfg_writes, mismatches);
        if (mismatches == 0)
            $display("sparse_block_gap_encoder_tb: done, clean");
        else
            $display("sparse_block_gap_encoder_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sbge_pkg.sv
hdl/sbge_fifo.sv
hdl/sbge_front.sv
hdl/sbge_back.sv
hdl/sparse_block_gap_encoder.sv
hdl/sbge_checker.sv
tb/sparse_block_gap_encoder_tb.sv
